@@ hw/rtl/pcpf_pkg.sv @@
package pcpf_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned AxisW    = 2;
  localparam int unsigned InDataW  = 12 * WordW;
  localparam int unsigned OutDataW = 7 * WordW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivCntW  = 7;
  localparam int unsigned SqrtCntW = 6;
  localparam int unsigned DotW     = 51;

  localparam logic [WordW-1:0] OneQ16 = 32'h0001_0000;
  localparam logic [WordW-1:0] MaxU32 = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRadius   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitMax = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoeff    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInvMm    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInvMs    = 3'd4;

  // iteration counts of the shared units
  localparam logic [DivCntW-1:0]  DivSteps48 = 7'd48;
  localparam logic [DivCntW-1:0]  DivSteps64 = 7'd64;
  localparam logic [SqrtCntW-1:0] SqrtSteps32 = 6'd32;
  localparam logic [SqrtCntW-1:0] SqrtSteps24 = 6'd24;

  typedef enum logic [3:0] {
    MUL_EM_SQ, MUL_EPS_SQ, MUL_Q_SR, MUL_COEF_P, MUL_FH_N, MUL_FL_N,
    MUL_GH_MM, MUL_GL_MM, MUL_GH_MS, MUL_GL_MS, MUL_DM_EM
  } mul_sel_e;

  typedef enum logic [4:0] {
    WB_NONE, WB_S_LOAD, WB_S_ADD, WB_EPS2, WB_R, WB_Q, WB_SR, WB_P, WB_P_MAX,
    WB_F, WB_N, WB_G_LOAD, WB_G_ADD, WB_AM_LOAD, WB_AM_ADD, WB_AS_LOAD,
    WB_AS_ADD, WB_DOT, WB_LIMIT
  } wb_sel_e;

  typedef enum logic [1:0] {DIV_Q, DIV_N, DIV_T} div_sel_e;
  typedef enum logic {SQ_R, SQ_P} sqrt_sel_e;

  typedef struct packed {
    logic             capture;
    logic             out_load;
    mul_sel_e         mul_sel;
    wb_sel_e          wb_sel;
    logic [AxisW-1:0] axis;
    logic             sqrt_start;
    sqrt_sel_e        sqrt_sel;
    logic             div_start;
    div_sel_e         div_sel;
  } cmd_t;

  typedef struct packed {
    logic contact;
    logic q_big;
    logic dot_neg;
    logic sqrt_busy;
    logic div_busy;
  } sts_t;

  // magnitude plus sign to saturated signed 32-bit
  function automatic logic [WordW-1:0] sat32(input logic [64:0] mag, input logic neg);
    logic [WordW-1:0] r;
    if (neg) begin
      if (mag >= 65'h0_8000_0000) r = 32'h8000_0000;
      else                        r = 32'd0 - mag[31:0];
    end else begin
      if (mag > 65'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else                       r = mag[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pcpf_sqrt.sv @@
module pcpf_sqrt import pcpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         rad_i,    // radicand, left aligned
  input  logic [SqrtCntW-1:0] steps_i,  // result bits to produce
  output logic                busy_o,
  output logic [WordW-1:0]    root_o
);

  logic                busy_q, busy_d;
  logic [SqrtCntW-1:0] cnt_q, cnt_d;
  logic [63:0]         x_q;
  logic [33:0]         rem_q;
  logic [WordW-1:0]    root_q;
  logic [35:0]         rem_sh, trial, rem_nx;
  logic                ge;

  // one result bit per cycle, two radicand bits in
  assign rem_sh = {rem_q, x_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rem_nx = ge ? rem_sh - trial : rem_sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != SqrtCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= rem_nx[33:0];
      root_q <= {root_q[WordW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

@@ hw/rtl/pcpf_div.sv @@
module pcpf_div import pcpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        num_i,    // dividend, left aligned
  input  logic [DotW-1:0]    den_i,
  input  logic [DivCntW-1:0] steps_i,  // quotient bits to produce
  output logic               busy_o,
  output logic [63:0]        quo_o
);

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [63:0]        n_q, quo_q;
  logic [DotW-1:0]    den_q, rem_q;
  logic [DotW:0]      sh, sub;
  logic               ge;

  // restoring division, one quotient bit per cycle
  assign sh  = {rem_q, n_q[63]};
  assign ge  = sh >= {1'b0, den_q};
  assign sub = sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[62:0], 1'b0};
      rem_q <= ge ? sub[DotW-1:0] : sh[DotW-1:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

@@ hw/rtl/pcpf_datapath.sv @@
module pcpf_datapath import pcpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_data_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_contact_o
);

  // configuration and running limit
  logic [WordW-1:0] eps_q, coeff_q, inv_mm_q, inv_ms_q, limit_q;

  // per item working registers
  logic [WordW-1:0] em_q [NumAxes];
  logic [WordW-1:0] dm_q [NumAxes];
  logic             es_q [NumAxes];
  logic             ds_q [NumAxes];
  logic [63:0]      s_q, eps2_q, prod_q, am_acc_q;
  logic [WordW-1:0] r_q, p_q;
  logic [47:0]      q_q, f_q, g_q;
  logic [23:0]      sr_q;
  logic [16:0]      n_q;
  logic [DotW-1:0]  dot_q;
  logic [WordW-1:0] acc_m_q [NumAxes];
  logic [WordW-1:0] acc_s_q [NumAxes];

  // result register
  logic             out_contact_q;
  logic [WordW-1:0] out_m_q [NumAxes];
  logic [WordW-1:0] out_s_q [NumAxes];
  logic [WordW-1:0] out_limit_q;

  logic [WordW-1:0] em_nx [NumAxes];
  logic [WordW-1:0] dm_nx [NumAxes];
  logic             es_nx [NumAxes];
  logic             ds_nx [NumAxes];
  logic [32:0]      pdiff [NumAxes];
  logic [32:0]      vdiff [NumAxes];

  logic [WordW-1:0]   mul_a, mul_b;
  logic [63:0]        sq_rad, div_num, quo;
  logic [SqrtCntW-1:0] sq_steps;
  logic [DivCntW-1:0] div_steps;
  logic [DotW-1:0]    div_den, dot_t;
  logic [WordW-1:0]   root, ratio;
  logic [64:0]        s_sum, acc_sum;
  logic               contact;

  // pair differences, sign and magnitude
  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      pdiff[k] = {in_data_i[WordW*(3+k)+31], in_data_i[WordW*(3+k) +: WordW]}
               - {in_data_i[WordW*k+31], in_data_i[WordW*k +: WordW]};
      vdiff[k] = {in_data_i[WordW*(9+k)+31], in_data_i[WordW*(9+k) +: WordW]}
               - {in_data_i[WordW*(6+k)+31], in_data_i[WordW*(6+k) +: WordW]};
      es_nx[k] = pdiff[k][32];
      ds_nx[k] = vdiff[k][32];
      em_nx[k] = es_nx[k] ? ~pdiff[k][31:0] + 32'd1 : pdiff[k][31:0];
      dm_nx[k] = ds_nx[k] ? ~vdiff[k][31:0] + 32'd1 : vdiff[k][31:0];
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_EM_SQ:  begin mul_a = em_q[cmd_i.axis];        mul_b = em_q[cmd_i.axis]; end
      MUL_EPS_SQ: begin mul_a = eps_q;                   mul_b = eps_q;            end
      MUL_Q_SR:   begin mul_a = q_q[31:0];               mul_b = {8'd0, sr_q};     end
      MUL_COEF_P: begin mul_a = coeff_q;                 mul_b = p_q;              end
      MUL_FH_N:   begin mul_a = f_q[47:16];              mul_b = {15'd0, n_q};     end
      MUL_FL_N:   begin mul_a = {16'd0, f_q[15:0]};      mul_b = {15'd0, n_q};     end
      MUL_GH_MM:  begin mul_a = g_q[47:16];              mul_b = inv_mm_q;         end
      MUL_GL_MM:  begin mul_a = {16'd0, g_q[15:0]};      mul_b = inv_mm_q;         end
      MUL_GH_MS:  begin mul_a = g_q[47:16];              mul_b = inv_ms_q;         end
      MUL_GL_MS:  begin mul_a = {16'd0, g_q[15:0]};      mul_b = inv_ms_q;         end
      MUL_DM_EM:  begin mul_a = dm_q[cmd_i.axis];        mul_b = em_q[cmd_i.axis]; end
      default:    begin mul_a = '0;                      mul_b = '0;               end
    endcase
  end

  always_comb begin
    case (cmd_i.sqrt_sel)
      SQ_R:    begin sq_rad = s_q;               sq_steps = SqrtSteps32; end
      SQ_P:    begin sq_rad = {q_q[31:0], 32'd0}; sq_steps = SqrtSteps24; end
      default: begin sq_rad = s_q;               sq_steps = SqrtSteps32; end
    endcase
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_Q: begin
        div_num = {eps_q, 32'd0};
        div_den = DotW'(r_q);
        div_steps = DivSteps48;
      end
      DIV_N: begin
        div_num = {em_q[cmd_i.axis], 32'd0};
        div_den = DotW'(r_q);
        div_steps = DivSteps48;
      end
      DIV_T: begin
        div_num = {s_q[63:16], 16'd0};
        div_den = DotW'(0) - dot_q;
        div_steps = DivSteps64;
      end
      default: begin
        div_num = '0;
        div_den = DotW'(r_q);
        div_steps = DivSteps64;
      end
    endcase
  end

  pcpf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (sq_rad),
    .steps_i (sq_steps),
    .busy_o  (sts_o.sqrt_busy),
    .root_o  (root)
  );

  pcpf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .busy_o  (sts_o.div_busy),
    .quo_o   (quo)
  );

  assign s_sum   = {1'b0, s_q} + {1'b0, prod_q};
  assign acc_sum = {1'b0, am_acc_q} + {17'd0, prod_q[63:16]};
  assign dot_t   = {3'd0, prod_q[63:16]};
  assign ratio   = (|quo[63:32]) ? MaxU32 : quo[31:0];
  assign contact = (s_q != 64'd0) && (s_q < eps2_q);

  assign sts_o.contact = contact;
  assign sts_o.q_big   = |q_q[47:32];
  assign sts_o.dot_neg = dot_q[DotW-1];

  // configuration and running limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q    <= OneQ16;
      coeff_q  <= OneQ16;
      inv_mm_q <= OneQ16;
      inv_ms_q <= OneQ16;
      limit_q  <= OneQ16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRadius:   eps_q    <= cfg_data_i;
        CfgLimitMax: limit_q  <= cfg_data_i;
        CfgCoeff:    coeff_q  <= cfg_data_i;
        CfgInvMm:    inv_mm_q <= cfg_data_i;
        CfgInvMs:    inv_ms_q <= cfg_data_i;
        default:     ;
      endcase
    end else if (cmd_i.wb_sel == WB_LIMIT && ratio < limit_q) begin
      limit_q <= ratio;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      for (int k = 0; k < NumAxes; k++) begin
        em_q[k]    <= em_nx[k];
        dm_q[k]    <= dm_nx[k];
        es_q[k]    <= es_nx[k];
        ds_q[k]    <= ds_nx[k];
        acc_m_q[k] <= '0;
        acc_s_q[k] <= '0;
      end
      dot_q <= '0;
    end
    case (cmd_i.wb_sel)
      WB_S_LOAD:  s_q    <= prod_q;
      WB_S_ADD:   s_q    <= s_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_sum[63:0];
      WB_EPS2:    eps2_q <= prod_q;
      WB_R:       r_q    <= root;
      WB_Q:       q_q    <= quo[47:0] - 48'h1_0000;
      WB_SR:      sr_q   <= root[23:0];
      WB_P:       p_q    <= (|prod_q[63:48]) ? MaxU32 : prod_q[47:16];
      WB_P_MAX:   p_q    <= MaxU32;
      WB_F:       f_q    <= prod_q[63:16];
      WB_N:       n_q    <= quo[16:0];
      WB_G_LOAD:  g_q    <= prod_q[47:0];
      WB_G_ADD:   g_q    <= g_q + prod_q[63:16];
      WB_AM_LOAD: am_acc_q <= prod_q;
      WB_AM_ADD:  acc_m_q[cmd_i.axis] <= sat32(acc_sum, !es_q[cmd_i.axis]);
      WB_AS_LOAD: am_acc_q <= prod_q;
      WB_AS_ADD:  acc_s_q[cmd_i.axis] <= sat32(acc_sum, es_q[cmd_i.axis]);
      WB_DOT:     dot_q <= (ds_q[cmd_i.axis] ^ es_q[cmd_i.axis]) ? dot_q - dot_t
                                                                 : dot_q + dot_t;
      default:    ;
    endcase
    if (cmd_i.out_load) begin
      out_contact_q <= contact;
      out_limit_q   <= limit_q;
      for (int k = 0; k < NumAxes; k++) begin
        out_m_q[k] <= acc_m_q[k];
        out_s_q[k] <= acc_s_q[k];
      end
    end
  end

  assign out_contact_o = out_contact_q;
  assign out_data_o = {out_limit_q, out_s_q[2], out_s_q[1], out_s_q[0],
                       out_m_q[2], out_m_q[1], out_m_q[0]};

endmodule

@@ hw/rtl/pcpf_ctrl.sv @@
module pcpf_ctrl import pcpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_CHK, ST_R, ST_DQ0, ST_DQ, ST_QCHK, ST_SP, ST_PF,
    ST_ND0, ST_ND, ST_AX, ST_TCHK, ST_DT, ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [AxisW-1:0] axis_q, axis_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    cmd_o            = '0;
    cmd_o.mul_sel    = MUL_EM_SQ;
    cmd_o.wb_sel     = WB_NONE;
    cmd_o.axis       = axis_q;
    cmd_o.sqrt_sel   = SQ_R;
    cmd_o.div_sel    = DIV_Q;

    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_PRE;
          cnt_d   = '0;
        end
      end
      ST_PRE: begin
        cmd_o.axis = cnt_q[AxisW-1:0];
        case (cnt_q)
          4'd0: cmd_o.mul_sel = MUL_EM_SQ;
          4'd1: begin cmd_o.mul_sel = MUL_EM_SQ;  cmd_o.wb_sel = WB_S_LOAD; end
          4'd2: begin cmd_o.mul_sel = MUL_EM_SQ;  cmd_o.wb_sel = WB_S_ADD;  end
          4'd3: begin cmd_o.mul_sel = MUL_EPS_SQ; cmd_o.wb_sel = WB_S_ADD;  end
          default: cmd_o.wb_sel = WB_EPS2;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd4) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd_o.sqrt_start = sts_i.contact;
        cmd_o.sqrt_sel   = SQ_R;
        state_d = sts_i.contact ? ST_R : ST_DONE;
      end
      ST_R: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.wb_sel = WB_R;
          state_d = ST_DQ0;
        end
      end
      ST_DQ0: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_Q;
        state_d = ST_DQ;
      end
      ST_DQ: begin
        if (!sts_i.div_busy) begin
          cmd_o.wb_sel = WB_Q;
          state_d = ST_QCHK;
        end
      end
      ST_QCHK: begin
        if (sts_i.q_big) begin
          cmd_o.wb_sel = WB_P_MAX;
          state_d = ST_PF;
          cnt_d   = 4'd2;
        end else begin
          cmd_o.sqrt_start = 1'b1;
          cmd_o.sqrt_sel   = SQ_P;
          state_d = ST_SP;
        end
      end
      ST_SP: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.wb_sel = WB_SR;
          state_d = ST_PF;
          cnt_d   = '0;
        end
      end
      ST_PF: begin
        case (cnt_q)
          4'd0: cmd_o.mul_sel = MUL_Q_SR;
          4'd1: cmd_o.wb_sel  = WB_P;
          4'd2: cmd_o.mul_sel = MUL_COEF_P;
          default: cmd_o.wb_sel = WB_F;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          state_d = ST_ND0;
          axis_d  = '0;
        end
      end
      ST_ND0: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_N;
        state_d = ST_ND;
      end
      ST_ND: begin
        if (!sts_i.div_busy) begin
          cmd_o.wb_sel = WB_N;
          state_d = ST_AX;
          cnt_d   = '0;
        end
      end
      ST_AX: begin
        // one axis: unit vector times force, both masses, dot term
        case (cnt_q)
          4'd0: cmd_o.mul_sel = MUL_FH_N;
          4'd1: begin cmd_o.mul_sel = MUL_FL_N;  cmd_o.wb_sel = WB_G_LOAD;  end
          4'd2: cmd_o.wb_sel = WB_G_ADD;
          4'd3: cmd_o.mul_sel = MUL_GH_MM;
          4'd4: begin cmd_o.mul_sel = MUL_GL_MM; cmd_o.wb_sel = WB_AM_LOAD; end
          4'd5: begin cmd_o.mul_sel = MUL_GH_MS; cmd_o.wb_sel = WB_AM_ADD;  end
          4'd6: begin cmd_o.mul_sel = MUL_GL_MS; cmd_o.wb_sel = WB_AS_LOAD; end
          4'd7: begin cmd_o.mul_sel = MUL_DM_EM; cmd_o.wb_sel = WB_AS_ADD;  end
          default: cmd_o.wb_sel = WB_DOT;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          if (axis_q == AxisW'(NumAxes - 1)) begin
            state_d = ST_TCHK;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = ST_ND0;
          end
        end
      end
      ST_TCHK: begin
        cmd_o.div_start = sts_i.dot_neg;
        cmd_o.div_sel   = DIV_T;
        state_d = sts_i.dot_neg ? ST_DT : ST_DONE;
      end
      ST_DT: begin
        if (!sts_i.div_busy) begin
          cmd_o.wb_sel = WB_LIMIT;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
        if (cmd_o.out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/penalty_contact_pair_force_top.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata: master pos x,y,z, slave pos x,y,z, master vel x,y,z,
//                      slave vel x,y,z (signed Q16.16 each)
// m_axis    out        tdata: master acc dx,dy,dz, slave acc dx,dy,dz, step limit;
//                      tuser: in_contact
// cfg       in         write enable, register index, 32-bit data
//
// One pair at a time. With contact the result waits on the bit-serial square root
// (32 and 24 steps) and the one-bit-per-cycle divider (three 48-step unit-vector
// quotients, one 48-step radius quotient, one 64-step step-limit quotient).
// Reset clears the control state and loads every config register with 1.0.
// A finished result sits in the output register, so the next pair is taken
// while m_axis is stalled; that pair waits only at its own hand-off.
module penalty_contact_pair_force_top import pcpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // from bit 0: master_pos_x/y/z, slave_pos_x/y/z, master_vel_x/y/z, slave_vel_x/y/z
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // from bit 0: master_acc_dx/dy/dz, slave_acc_dx/dy/dz, step_limit
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // bit 0: in_contact
  output logic [0:0]          m_axis_tuser_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: walks the item through multiply, root and divide steps
  pcpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: one 32x32 multiplier, shared root and divide units, result register
  pcpf_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (s_axis_tdata_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_data_o    (m_axis_tdata_o),
    .out_contact_o (m_axis_tuser_o[0])
  );

endmodule

@@ hw/rtl/pcpf_checker.sv @@
module pcpf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [223:0] m_axis_tdata_o,
  input logic [0:0]   m_axis_tuser_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // no contact means no acceleration change
  a_no_contact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[191:0] == 192'd0)
    else $error("acceleration without contact");

  // one pair in flight
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second pair taken while busy");

  // a result never appears right after a transfer in
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result too early");

endmodule

bind penalty_contact_pair_force_top pcpf_checker u_pcpf_checker (.*);
